// ===== sv/poly_surface_evaluator_core_macros.svh =====
// assertion macros shared by the surface evaluator rtl
`ifndef POLY_SURFACE_EVALUATOR_CORE_MACROS_SVH
`define POLY_SURFACE_EVALUATOR_CORE_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define PSE_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("surface evaluator: same-cycle check failed");

// next-cycle implication, checked on aclk outside reset
`define PSE_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("surface evaluator: next-cycle check failed");

`endif

// ===== sv/pse_pkg.sv =====
// shared widths, constants, register indexes and rounding helper
`default_nettype none

package pse_pkg;

    localparam int PIXEL_W    = 16;
    localparam int SCALE_W    = 24;
    localparam int COEF_W     = 32;
    localparam int FRAC       = 24;
    localparam int NORM_W     = 27;
    localparam int MONO_W     = 2 * NORM_W - FRAC;
    localparam int ACC_W      = 64;
    localparam int RES_W      = 32;
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    localparam int DEF_MAX_DEGREE = 2;
    localparam int DEF_COORD_BITS = 16;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(4096);

    // normalised coordinate: one in q24, clamp value and clamp threshold
    localparam logic [NORM_W-1:0]        NORM_ONE   = NORM_W'(1 << FRAC);
    localparam logic signed [NORM_W-1:0] NORM_MAX   = NORM_W'((1 << 26) - 1);
    localparam logic [63:0]              NORM_LIMIT = 64'((1 << 26) - 1 + (1 << FRAC));

    localparam logic [RES_W-1:0] RES_MAX = 32'h7fff_ffff;
    localparam logic [RES_W-1:0] RES_MIN = 32'h8000_0000;

    typedef enum logic [2:0] {
        REG_COEF_CONST = 3'd0,
        REG_COEF_Y     = 3'd1,
        REG_COEF_X     = 3'd2,
        REG_COEF_YY    = 3'd3,
        REG_COEF_XY    = 3'd4,
        REG_COEF_XX    = 3'd5,
        REG_X_SCALE    = 3'd6,
        REG_Y_SCALE    = 3'd7
    } reg_idx_t;

    // q48 product to q24, half rounds towards plus infinity
    function automatic logic signed [MONO_W-1:0] round_mono(
        input logic signed [2*NORM_W-1:0] p
    );
        logic [2*NORM_W-1:0] s;
        s = p + (2*NORM_W)'(1 << (FRAC - 1));
        return s[2*NORM_W-1:FRAC];
    endfunction

endpackage

`default_nettype wire

// ===== sv/pse_norm.sv =====
// coordinate normalisation: coord*scale, round to q24, clamp, minus one
`default_nettype none

module pse_norm
    import pse_pkg::*;
#(
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                      aclk,
    input  wire logic                      pipe_en,
    input  wire logic [PIXEL_W-1:0]        coord,
    input  wire logic [SCALE_W-1:0]        scale,
    output logic signed [NORM_W-1:0]       norm
);

    localparam int CW    = (COORD_BITS < PIXEL_W) ? COORD_BITS : PIXEL_W;
    localparam int RAW_W = CW + SCALE_W;
    localparam int QW    = RAW_W - 2;

    logic [RAW_W-1:0]         raw_reg, raw_next;
    logic [RAW_W:0]           rnd;
    logic [QW-1:0]            q24;
    logic signed [NORM_W-1:0] norm_reg, norm_next;

    // stage one: coordinate times scale, 27 fraction bits
    assign raw_next = coord[CW-1:0] * scale;

    // stage two: round to 24 fraction bits, clamp, subtract one
    always_comb begin
        rnd = {1'b0, raw_reg} + (RAW_W+1)'(4);
        q24 = rnd[RAW_W:3];
        if (64'(q24) > NORM_LIMIT) begin
            norm_next = NORM_MAX;
        end else begin
            norm_next = NORM_W'(q24) - NORM_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            raw_reg  <= raw_next;
            norm_reg <= norm_next;
        end
    end

    assign norm = norm_reg;

endmodule

`default_nettype wire

// ===== sv/pse_mono.sv =====
// quadratic monomials y*y, x*y, x*x rounded to q24, with coordinate delay
`default_nettype none

module pse_mono
    import pse_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE
) (
    input  wire logic                     aclk,
    input  wire logic                     pipe_en,
    input  wire logic signed [NORM_W-1:0] nx,
    input  wire logic signed [NORM_W-1:0] ny,
    output logic signed [NORM_W-1:0]      nx_d,
    output logic signed [NORM_W-1:0]      ny_d,
    output logic signed [MONO_W-1:0]      myy,
    output logic signed [MONO_W-1:0]      mxy,
    output logic signed [MONO_W-1:0]      mxx
);

    logic signed [NORM_W-1:0] nx1_reg, ny1_reg, nx2_reg, ny2_reg;

    // linear terms wait two stages alongside the monomials
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            nx1_reg <= nx;
            ny1_reg <= ny;
            nx2_reg <= nx1_reg;
            ny2_reg <= ny1_reg;
        end
    end

    assign nx_d = nx2_reg;
    assign ny_d = ny2_reg;

    generate
        if (MAX_DEGREE >= 2) begin : g_quad
            logic signed [2*NORM_W-1:0] pyy_reg, pxy_reg, pxx_reg;
            logic signed [2*NORM_W-1:0] pyy_next, pxy_next, pxx_next;
            logic signed [MONO_W-1:0]   myy_reg, mxy_reg, mxx_reg;

            // exact q48 products
            assign pyy_next = ny * ny;
            assign pxy_next = nx * ny;
            assign pxx_next = nx * nx;

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    pyy_reg <= pyy_next;
                    pxy_reg <= pxy_next;
                    pxx_reg <= pxx_next;
                    myy_reg <= round_mono(pyy_reg);
                    mxy_reg <= round_mono(pxy_reg);
                    mxx_reg <= round_mono(pxx_reg);
                end
            end

            assign myy = myy_reg;
            assign mxy = mxy_reg;
            assign mxx = mxx_reg;
        end else begin : g_lin
            // first-degree surface: quadratic terms drop out
            assign myy = '0;
            assign mxy = '0;
            assign mxx = '0;
        end
    endgenerate

endmodule

`default_nettype wire

// ===== sv/pse_mac.sv =====
// coefficient products and exact q48 sum in three stages
`default_nettype none

module pse_mac
    import pse_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     pipe_en,
    input  wire logic signed [COEF_W-1:0] coef_const,
    input  wire logic signed [COEF_W-1:0] coef_y,
    input  wire logic signed [COEF_W-1:0] coef_x,
    input  wire logic signed [COEF_W-1:0] coef_yy,
    input  wire logic signed [COEF_W-1:0] coef_xy,
    input  wire logic signed [COEF_W-1:0] coef_xx,
    input  wire logic signed [NORM_W-1:0] nx,
    input  wire logic signed [NORM_W-1:0] ny,
    input  wire logic signed [MONO_W-1:0] myy,
    input  wire logic signed [MONO_W-1:0] mxy,
    input  wire logic signed [MONO_W-1:0] mxx,
    output logic signed [ACC_W-1:0]       acc
);

    localparam int PC_W = COEF_W + FRAC;
    localparam int PL_W = COEF_W + NORM_W;
    localparam int PQ_W = COEF_W + MONO_W;

    logic signed [PC_W-1:0]  pc_reg, pc_next;
    logic signed [PL_W-1:0]  py_reg, px_reg, py_next, px_next;
    logic signed [PQ_W-1:0]  pyy_reg, pxy_reg, pxx_reg, pyy_next, pxy_next, pxx_next;
    logic signed [ACC_W-1:0] sa_reg, sb_reg, sc_reg, sa_next, sb_next, sc_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;

    // stage one: five multiplies, constant term is a shift
    assign pc_next  = {coef_const, FRAC'(0)};
    assign py_next  = coef_y * ny;
    assign px_next  = coef_x * nx;
    assign pyy_next = coef_yy * myy;
    assign pxy_next = coef_xy * mxy;
    assign pxx_next = coef_xx * mxx;

    // stage two: pairwise sums
    assign sa_next = ACC_W'(pc_reg) + ACC_W'(py_reg);
    assign sb_next = ACC_W'(px_reg) + ACC_W'(pyy_reg);
    assign sc_next = ACC_W'(pxy_reg) + ACC_W'(pxx_reg);

    // stage three: final sum
    assign acc_next = sa_reg + sb_reg + sc_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pc_reg  <= pc_next;
            py_reg  <= py_next;
            px_reg  <= px_next;
            pyy_reg <= pyy_next;
            pxy_reg <= pxy_next;
            pxx_reg <= pxx_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
            sc_reg  <= sc_next;
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

// ===== sv/poly_surface_evaluator_core.sv =====
// Second-degree polynomial surface evaluator, top level.
// Input stream s_*: one pixel coordinate pair per item, both unsigned with
// 4 fraction bits. Result stream m_*: the surface value (signed, 24 fraction
// bits, saturated to 32 bits) in m_tdata and the clip flag in m_tuser.
// Coefficients and the two scales are written over the APB port at byte
// address 4*index; writes are meant for when the stream is idle.
// From acceptance to m_tvalid an item passes through normalisation, the
// monomial products and their rounding, the coefficient multiplies and
// the adder tree, and rounding and saturation into the output register.
// Throughput is one item per cycle while no result waits on a stalled
// receiver; the 27x27 and 32x30 multipliers each sit in a stage of their
// own and set the stage depth.
// Reset clears all valid bits, sets the coefficients to zero and both
// scales to 4096.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline freezes and s_tready drops in the same cycle; nothing is lost or
// repeated, and flow resumes as soon as m_tready returns.
`default_nettype none

`include "poly_surface_evaluator_core_macros.svh"

module poly_surface_evaluator_core
    import pse_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    // result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // [31:0] surface_value
    output logic [0:0]                 m_tuser,   // [0] saturated
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0]      prdata,
    output logic                       pready
);

    localparam int PIPE_DEPTH = 7;
    localparam int RR_W       = ACC_W - FRAC;

    // configuration registers
    logic signed [COEF_W-1:0] coef_const_reg, coef_y_reg, coef_x_reg;
    logic signed [COEF_W-1:0] coef_yy_reg, coef_xy_reg, coef_xx_reg;
    logic [SCALE_W-1:0]       x_scale_reg, y_scale_reg;
    logic                     cfg_wr;
    reg_idx_t                 cfg_idx;

    // pipeline control and datapath
    logic                     pipe_en;
    logic [PIPE_DEPTH-1:0]    valid_reg, valid_next;
    logic signed [NORM_W-1:0] nx, ny, nx_d, ny_d;
    logic signed [MONO_W-1:0] myy, mxy, mxx;
    logic signed [ACC_W-1:0]  acc;
    logic [ACC_W-1:0]         acc_rnd;
    logic [RR_W-1:0]          rr;
    logic                     ovf;
    logic                     m_tvalid_reg;
    logic [RES_W-1:0]         res_reg, res_next;
    logic                     sat_reg;

    // apb register file
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_const_reg <= '0;
            coef_y_reg     <= '0;
            coef_x_reg     <= '0;
            coef_yy_reg    <= '0;
            coef_xy_reg    <= '0;
            coef_xx_reg    <= '0;
            x_scale_reg    <= SCALE_RESET;
            y_scale_reg    <= SCALE_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_COEF_CONST: coef_const_reg <= pwdata;
                REG_COEF_Y:     coef_y_reg     <= pwdata;
                REG_COEF_X:     coef_x_reg     <= pwdata;
                REG_COEF_YY:    coef_yy_reg    <= pwdata;
                REG_COEF_XY:    coef_xy_reg    <= pwdata;
                REG_COEF_XX:    coef_xx_reg    <= pwdata;
                REG_X_SCALE:    x_scale_reg    <= pwdata[SCALE_W-1:0];
                REG_Y_SCALE:    y_scale_reg    <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // register read-back
    always_comb begin
        case (cfg_idx)
            REG_COEF_CONST: prdata = coef_const_reg;
            REG_COEF_Y:     prdata = coef_y_reg;
            REG_COEF_X:     prdata = coef_x_reg;
            REG_COEF_YY:    prdata = coef_yy_reg;
            REG_COEF_XY:    prdata = coef_xy_reg;
            REG_COEF_XX:    prdata = coef_xx_reg;
            REG_X_SCALE:    prdata = CFG_DATA_W'(x_scale_reg);
            REG_Y_SCALE:    prdata = CFG_DATA_W'(y_scale_reg);
            default:        prdata = '0;
        endcase
    end

    // whole pipe advances unless a result waits on a stalled receiver
    assign pipe_en    = !m_tvalid_reg || m_tready;
    assign s_tready   = pipe_en;
    assign valid_next = {valid_reg[PIPE_DEPTH-2:0], s_tvalid};

    // datapath stages
    pse_norm #(.COORD_BITS(COORD_BITS)) u_norm_x (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .coord   (s_tdata[PIXEL_W-1:0]),
        .scale   (x_scale_reg),
        .norm    (nx)
    );

    pse_norm #(.COORD_BITS(COORD_BITS)) u_norm_y (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .coord   (s_tdata[2*PIXEL_W-1:PIXEL_W]),
        .scale   (y_scale_reg),
        .norm    (ny)
    );

    pse_mono #(.MAX_DEGREE(MAX_DEGREE)) u_mono (
        .aclk    (aclk),
        .pipe_en (pipe_en),
        .nx      (nx),
        .ny      (ny),
        .nx_d    (nx_d),
        .ny_d    (ny_d),
        .myy     (myy),
        .mxy     (mxy),
        .mxx     (mxx)
    );

    pse_mac u_mac (
        .aclk       (aclk),
        .pipe_en    (pipe_en),
        .coef_const (coef_const_reg),
        .coef_y     (coef_y_reg),
        .coef_x     (coef_x_reg),
        .coef_yy    (coef_yy_reg),
        .coef_xy    (coef_xy_reg),
        .coef_xx    (coef_xx_reg),
        .nx         (nx_d),
        .ny         (ny_d),
        .myy        (myy),
        .mxy        (mxy),
        .mxx        (mxx),
        .acc        (acc)
    );

    // round q48 sum to q24 and saturate to 32 bits
    always_comb begin
        acc_rnd = acc + ACC_W'(1 << (FRAC - 1));
        rr      = acc_rnd[ACC_W-1:FRAC];
        ovf     = !((&rr[RR_W-1:RES_W-1]) || !(|rr[RR_W-1:RES_W-1]));
        if (ovf) begin
            res_next = rr[RR_W-1] ? RES_MIN : RES_MAX;
        end else begin
            res_next = rr[RES_W-1:0];
        end
    end

    // valid chain and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (pipe_en) begin
            valid_reg    <= valid_next;
            m_tvalid_reg <= valid_reg[PIPE_DEPTH-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            res_reg <= res_next;
            sat_reg <= ovf;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = res_reg;
    assign m_tuser[0] = sat_reg;

    // checks
    `PSE_ASSERT_IMPL(a_sat_value, m_tvalid && m_tuser[0], (m_tdata == RES_MAX) || (m_tdata == RES_MIN))
    `PSE_ASSERT_NEXT(a_frozen_valid, !pipe_en, $stable(valid_reg) && $stable(m_tvalid_reg))
    `PSE_ASSERT_IMPL(a_out_from_pipe, $rose(m_tvalid_reg), $past(valid_reg[PIPE_DEPTH-1]))

endmodule

`default_nettype wire

// ===== dv/poly_surface_evaluator_core_checker.sv =====
// checker for the surface evaluator: tracks the registers, predicts each result and compares
module poly_surface_evaluator_core_checker
    import pse_pkg::*;
#(
    parameter int MAX_DEGREE = DEF_MAX_DEGREE,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [31:0]           s_tdata,   // [15:0] pixel_x, [31:16] pixel_y
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [31:0]           m_tdata,   // [31:0] surface_value
    input  wire logic [0:0]            m_tuser,   // [0] saturated
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    output int                         pending,
    output int                         fail_count
);

    typedef struct packed {
        logic [31:0] value;
        logic        clip;
    } surface_t;

    localparam longint UNIT_Q24 = longint'(1) <<< 24;
    localparam longint NORM_CAP = (longint'(1) <<< 26) - 1;
    localparam longint RES_HI   = 64'sd2147483647;
    localparam longint RES_LO   = -RES_HI - 1;

    logic signed [31:0] coef_q [6];
    logic [SCALE_W-1:0] scale_x_q;
    logic [SCALE_W-1:0] scale_y_q;
    surface_t           surface_q [$];
    surface_t           want;
    surface_t           predicted;
    reg_idx_t           wr_idx;
    int                 shown = 0;

    // coordinate (4 frac) times scale (23 frac), rounded to q24, minus one, clamped above
    function automatic longint norm_coord(logic [15:0] coord, logic [SCALE_W-1:0] scale);
        longint c;
        longint q24;
        c = longint'(coord);
        if (COORD_BITS < 16) c = c & ((longint'(1) <<< COORD_BITS) - 1);
        q24 = (c * longint'(scale) + 4) >>> 3;
        if (q24 > NORM_CAP + UNIT_Q24) return NORM_CAP;
        return q24 - UNIT_Q24;
    endfunction

    // drop 24 fraction bits, half rounds towards plus infinity
    function automatic longint round_q24(longint v);
        return (v + (longint'(1) <<< 23)) >>> 24;
    endfunction

    // surface value at one pixel under the current coefficients and scales
    function automatic surface_t predict_surface(logic [15:0] px, logic [15:0] py);
        longint   nx;
        longint   ny;
        longint   acc;
        longint   res;
        surface_t r;
        nx  = norm_coord(px, scale_x_q);
        ny  = norm_coord(py, scale_y_q);
        acc = longint'(coef_q[REG_COEF_CONST]) * UNIT_Q24;
        acc += longint'(coef_q[REG_COEF_Y]) * ny;
        acc += longint'(coef_q[REG_COEF_X]) * nx;
        if (MAX_DEGREE >= 2) begin
            acc += longint'(coef_q[REG_COEF_YY]) * round_q24(ny * ny);
            acc += longint'(coef_q[REG_COEF_XY]) * round_q24(nx * ny);
            acc += longint'(coef_q[REG_COEF_XX]) * round_q24(nx * nx);
        end
        res    = round_q24(acc);
        r.clip = 1'b0;
        if (res > RES_HI) begin
            res    = RES_HI;
            r.clip = 1'b1;
        end else if (res < RES_LO) begin
            res    = RES_LO;
            r.clip = 1'b1;
        end
        r.value = 32'(res);
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) coef_q[i] = '0;
            scale_x_q = SCALE_RESET;
            scale_y_q = SCALE_RESET;
            surface_q.delete();
            pending <= 0;
        end else begin
            // each accepted item is predicted with the settings in force
            if (s_tvalid && s_tready) begin
                predicted = predict_surface(s_tdata[15:0], s_tdata[31:16]);
                surface_q = {surface_q, predicted};
            end

            // register writes
            if (psel && penable && pwrite && pready) begin
                wr_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
                if (wr_idx <= REG_COEF_XX) coef_q[wr_idx] = pwdata[31:0];
                else if (wr_idx == REG_X_SCALE) scale_x_q = pwdata[SCALE_W-1:0];
                else scale_y_q = pwdata[SCALE_W-1:0];
            end

            // compare each result item with the oldest prediction
            if (m_tvalid && m_tready) begin
                if (surface_q.size() == 0) begin
                    fail_count++;
                    if (shown < 10) $display("unexpected result: value %h clip %0d",
                                             m_tdata, m_tuser[0]);
                    shown++;
                end else begin
                    want = surface_q.pop_front();
                    if (want.value !== m_tdata || want.clip !== m_tuser[0]) begin
                        fail_count++;
                        if (shown < 10)
                            $display("mismatch: expected value %h clip %0d, %s %h clip %0d",
                                     want.value, want.clip, "got value",
                                     m_tdata, m_tuser[0]);
                        shown++;
                    end
                end
            end
            pending <= surface_q.size();
        end
    end

endmodule

// ===== dv/poly_surface_evaluator_core_tb.sv =====
// testbench top for the surface evaluator: clock, reset, stimulus and verdict
module poly_surface_evaluator_core_tb;
    import pse_pkg::*;

    localparam int DEGREE       = 2;
    localparam int COORD_W      = 16;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RAND_PHASES  = 18;
    localparam int PHASE_ITEMS  = 105;
    localparam int DRAIN_CYCLES = 16;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr    = '0;
    logic [CFG_DATA_W-1:0] pwdata   = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int pending;
    int fail_count;
    int cycle_count = 0;
    int tx_idle_pct = 13;
    int rx_idle_pct = 69;

    always #2 aclk = ~aclk;

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    // receiver back-pressure
    always @(posedge aclk) m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);

    poly_surface_evaluator_core #(
        .MAX_DEGREE (DEGREE),
        .COORD_BITS (COORD_W)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    poly_surface_evaluator_core_checker #(
        .MAX_DEGREE (DEGREE),
        .COORD_BITS (COORD_W)
    ) u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .pending    (pending),
        .fail_count (fail_count)
    );

    // setup cycle, then access cycle until pready
    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_coefs(logic [31:0] c0, logic [31:0] cy, logic [31:0] cx,
                               logic [31:0] cyy, logic [31:0] cxy, logic [31:0] cxx);
        write_reg(REG_COEF_CONST, c0);
        write_reg(REG_COEF_Y, cy);
        write_reg(REG_COEF_X, cx);
        write_reg(REG_COEF_YY, cyy);
        write_reg(REG_COEF_XY, cxy);
        write_reg(REG_COEF_XX, cxx);
    endtask

    // one item, each cycle in front of it idle at the sender's idle rate
    task automatic send_pixel(logic [15:0] px, logic [15:0] py);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {py, px};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // stop sending and wait until every predicted result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // 2/size with 23 fraction bits, zero for a zero size
    function automatic logic [31:0] scale_for(int size);
        longint s;
        if (size == 0) return '0;
        s = ((longint'(1) <<< 24) + size / 2) / size;
        if (s > 64'hff_ffff) s = 64'hff_ffff;
        return 32'(s);
    endfunction

    function automatic logic [31:0] rand_coef(bit tame);
        if (tame) return 32'(int'($urandom_range(0, 1 << 26)) - (1 << 25));
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h8000_0000;
            3:       return 32'(int'($urandom_range(0, 32)) - 16);
            default: return $urandom;
        endcase
    endfunction

    // mostly inside the image when tame, otherwise anywhere in the coordinate range
    function automatic logic [15:0] rand_coord(bit tame, int size);
        if (tame && $urandom_range(0, 9) < 8) return 16'($urandom_range(0, size * 16));
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] rand_scale(bit tame, int size);
        if (tame) return scale_for(size);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 32'h00ff_ffff;
            2:       return {8'h00, 24'($urandom)};
            default: return scale_for(size);
        endcase
    endfunction

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        bit tame;
        int width_px;
        int height_px;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: zero coefficients
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'h1234, 16'hfedc);
        drain();

        // an ordinary surface over a 640x480 image
        write_coefs(32'(1 << 24), 32'(1 << 23), 32'(-(1 << 22)),
                    32'(3 << 20), 32'(-(5 << 19)), 32'(1 << 21));
        write_reg(REG_X_SCALE, scale_for(640));
        write_reg(REG_Y_SCALE, scale_for(480));
        send_pixel(16'd0, 16'd0);
        send_pixel(16'(640 * 16), 16'(480 * 16));
        send_pixel(16'(320 * 16), 16'(240 * 16));
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'd1, 16'd0);
        drain();

        // zero scales give exactly -1, largest positive coefficients
        write_coefs(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                    32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        write_reg(REG_X_SCALE, 32'h0);
        write_reg(REG_Y_SCALE, 32'h0);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'd12345, 16'd54321);
        drain();

        // largest scales push coordinates past the image, most negative coefficients
        write_coefs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        write_reg(REG_X_SCALE, 32'h00ff_ffff);
        write_reg(REG_Y_SCALE, 32'h00ff_ffff);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'hffff, 16'h0000);
        send_pixel(16'h0000, 16'hffff);
        send_pixel(16'h8000, 16'h8000);
        drain();

        // first-order terms only, mixed extremes
        write_coefs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0, 32'h0);
        send_pixel(16'h0000, 16'h0000);
        send_pixel(16'hffff, 16'hffff);
        send_pixel(16'h0001, 16'h0001);
        drain();

        // one-lsb coefficients at reset scales, where rounding ties show up
        write_coefs(32'h1, 32'hffff_ffff, 32'h1, 32'hffff_ffff, 32'h1, 32'h1);
        write_reg(REG_X_SCALE, 32'(SCALE_RESET));
        write_reg(REG_Y_SCALE, 32'(SCALE_RESET));
        send_pixel(16'h0800, 16'h0800);
        send_pixel(16'h0001, 16'h0fff);
        send_pixel(16'h1000, 16'h0000);
        drain();

        // random phases: mostly realistic images, some with wild settings
        for (int p = 0; p < RAND_PHASES; p++) begin
            if (p < RAND_PHASES / 3) begin
                tx_idle_pct = 13;
                rx_idle_pct = 69;
            end else if (p < 2 * RAND_PHASES / 3) begin
                tx_idle_pct = 69;
                rx_idle_pct = 13;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            tame      = ($urandom_range(0, 9) < 7);
            width_px  = $urandom_range(2, 4095);
            height_px = $urandom_range(2, 4095);
            write_coefs(rand_coef(tame), rand_coef(tame), rand_coef(tame),
                        rand_coef(tame), rand_coef(tame), rand_coef(tame));
            write_reg(REG_X_SCALE, rand_scale(tame, width_px));
            write_reg(REG_Y_SCALE, rand_scale(tame, height_px));
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_pixel(rand_coord(tame, width_px), rand_coord(tame, height_px));
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) $display("PASS");
        else $display("FAIL");
        $finish;
    end

endmodule
